@@ src/fpr_pkg.sv @@
`timescale 1ns / 1ps

package fpr_pkg;

    // word format: signed q16.16
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int SHIFT_W   = $clog2(WORD_BITS - FRAC_BITS + 1);

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [SHIFT_W-1:0]          shamt_t;

    // how the operand was scaled, carried along to the back end
    typedef struct packed {
        logic   neg;
        shamt_t rs;
        shamt_t ls;
    } scale_t;

    localparam word_t ONE   = word_t'(64'd1 << FRAC_BITS);
    localparam word_t HALF  = word_t'(64'd1 << (FRAC_BITS - 1));
    localparam word_t TWO   = word_t'(64'd2 << FRAC_BITS);
    // 48/17 and 32/17, truncated toward minus infinity
    localparam word_t SEED_C48 = word_t'((64'd48 << FRAC_BITS) / 64'd17);
    localparam word_t SEED_C32 = word_t'((64'd32 << FRAC_BITS) / 64'd17);

    // full signed product, floor to FRAC_BITS fraction bits, wrapped
    function automatic word_t fx_mulq(input word_t a, input word_t b);
        logic signed [2*WORD_BITS-1:0] p;
        p = (2*WORD_BITS)'(a) * (2*WORD_BITS)'(b);
        return word_t'(p[FRAC_BITS +: WORD_BITS]);
    endfunction

endpackage

@@ src/fpr_norm.sv @@
`timescale 1ns / 1ps

module fpr_norm
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  fpr_pkg::word_t value,
    output logic           out_valid,
    output fpr_pkg::word_t d_norm,
    output fpr_pkg::scale_t scale
);
    import fpr_pkg::*;

    logic   v1_reg, v2_reg, v3_reg;
    logic   neg1_reg, neg2_reg;
    word_t  d1_reg, d2_reg, d3_reg;
    word_t  d1_next, d3_next;
    shamt_t rs2_reg, ls2_reg, rs_next, ls_next;
    scale_t sc3_reg;

    // magnitude, wraps on the most negative value
    always_comb
    begin
        d1_next = value[WORD_BITS-1] ? word_t'(-value) : value;
    end

    // leading-one search for both directions
    always_comb
    begin
        rs_next = '0;
        ls_next = '0;
        if (d1_reg > ONE)
        begin
            for (int i = FRAC_BITS; i < WORD_BITS; i++)
            begin
                if (d1_reg[i])
                    rs_next = shamt_t'(i - FRAC_BITS + 1);
            end
        end
        if (d1_reg < HALF)
        begin
            for (int i = 0; i < FRAC_BITS - 1; i++)
            begin
                if (d1_reg[i])
                    ls_next = shamt_t'(FRAC_BITS - 1 - i);
            end
        end
    end

    always_comb
    begin
        if (rs2_reg != '0)
            d3_next = d2_reg >> rs2_reg;
        else
            d3_next = d2_reg << ls2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg    <= value[WORD_BITS-1];
            d1_reg      <= d1_next;
            neg2_reg    <= neg1_reg;
            d2_reg      <= d1_reg;
            rs2_reg     <= rs_next;
            ls2_reg     <= ls_next;
            d3_reg      <= d3_next;
            sc3_reg.neg <= neg2_reg;
            sc3_reg.rs  <= rs2_reg;
            sc3_reg.ls  <= ls2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign d_norm    = d3_reg;
    assign scale     = sc3_reg;

endmodule

@@ src/fpr_newton.sv @@
`timescale 1ns / 1ps

module fpr_newton
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  fpr_pkg::word_t  x_in,
    input  fpr_pkg::word_t  d_in,
    input  fpr_pkg::scale_t scale_in,
    output logic            out_valid,
    output fpr_pkg::word_t  x_out,
    output fpr_pkg::word_t  d_out,
    output fpr_pkg::scale_t scale_out
);
    import fpr_pkg::*;

    logic   va_reg, vb_reg;
    word_t  t_reg, xa_reg, da_reg, xb_reg, db_reg;
    scale_t sca_reg, scb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    // t = 2 - x*d, then x = x*t
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg   <= word_t'(TWO - fx_mulq(x_in, d_in));
            xa_reg  <= x_in;
            da_reg  <= d_in;
            sca_reg <= scale_in;
            xb_reg  <= fx_mulq(xa_reg, t_reg);
            db_reg  <= da_reg;
            scb_reg <= sca_reg;
        end
    end

    assign out_valid = vb_reg;
    assign x_out     = xb_reg;
    assign d_out     = db_reg;
    assign scale_out = scb_reg;

endmodule

@@ src/fpr_denorm.sv @@
`timescale 1ns / 1ps

module fpr_denorm
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  fpr_pkg::word_t  x_in,
    input  fpr_pkg::scale_t scale_in,
    output logic            out_valid,
    output fpr_pkg::word_t  result
);
    import fpr_pkg::*;

    logic  v1_reg, v2_reg, neg1_reg;
    word_t z1_reg, z1_next, r2_reg;

    // same shift, same direction as the operand
    always_comb
    begin
        if (scale_in.rs != '0)
            z1_next = x_in >>> scale_in.rs;
        else
            z1_next = x_in << scale_in.ls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z1_reg   <= z1_next;
            neg1_reg <= scale_in.neg;
            r2_reg   <= neg1_reg ? word_t'(-z1_reg) : z1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign result    = r2_reg;

endmodule

@@ src/fixed_point_reciprocal_core.sv @@
`timescale 1ns / 1ps

// channel   dir  tdata                      tuser  tlast
// s_axis    in   [31:0] value (q16.16)      -      -
// m_axis    out  [31:0] reciprocal (q16.16) -      -
//
// one word per cycle while the output is not stalled; the stages are
// three normalize stages, one seed stage, two stages per newton step
// (multiply-subtract, then multiply), two stages for rescale and sign
// rst_n clears every valid bit and the skid buffer; data registers keep junk
// the whole pipe advances together whenever the output register is empty or
// being read; a word that arrives during a stall parks in a one-entry skid
// buffer, so s_tready is a register and drops only after a stalled cycle

module fixed_point_reciprocal_core #(
    parameter int NEWTON_STEPS = 4
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  fpr_pkg::word_t s_tdata,   // [31:0] value
    output logic           m_tvalid,
    input  logic           m_tready,
    output fpr_pkg::word_t m_tdata    // [31:0] reciprocal
);
    import fpr_pkg::*;

    logic  adv;
    logic  in_fire;
    logic  skid_valid_reg, skid_valid_next;
    word_t skid_data_reg;
    logic  src_valid;
    word_t src_data;

    // normalize stage outputs
    logic   norm_valid;
    word_t  norm_d;
    scale_t norm_scale;

    // seed stage
    logic   seed_valid_reg;
    word_t  seed_x_reg, seed_d_reg;
    scale_t seed_scale_reg;

    // newton chain, entry 0 is the seed
    logic   ch_valid [NEWTON_STEPS+1];
    word_t  ch_x     [NEWTON_STEPS+1];
    word_t  ch_d     [NEWTON_STEPS+1];
    scale_t ch_scale [NEWTON_STEPS+1];

    // whole pipe moves when the output register can take a word
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = !skid_valid_reg;
    assign in_fire  = s_tvalid && s_tready;

    // skid word goes first, it is older than anything at the port
    assign src_valid = skid_valid_reg || in_fire;
    assign src_data  = skid_valid_reg ? skid_data_reg : s_tdata;

    always_comb
    begin
        if (adv)
            skid_valid_next = 1'b0;
        else if (in_fire)
            skid_valid_next = 1'b1;
        else
            skid_valid_next = skid_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_valid_reg <= 1'b0;
        else
            skid_valid_reg <= skid_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && !adv)
            skid_data_reg <= s_tdata;
    end

    // magnitude, leading-one search, shift into [0.5,1] unless zero or most negative
    fpr_norm u_norm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (src_valid),
        .value     (src_data),
        .out_valid (norm_valid),
        .d_norm    (norm_d),
        .scale     (norm_scale)
    );

    // seed x0 = 48/17 - 32/17*d
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_valid_reg <= 1'b0;
        else if (adv)
            seed_valid_reg <= norm_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            seed_x_reg     <= word_t'(SEED_C48 - fx_mulq(SEED_C32, norm_d));
            seed_d_reg     <= norm_d;
            seed_scale_reg <= norm_scale;
        end
    end

    assign ch_valid[0] = seed_valid_reg;
    assign ch_x[0]     = seed_x_reg;
    assign ch_d[0]     = seed_d_reg;
    assign ch_scale[0] = seed_scale_reg;

    // x = x*(2 - x*d), one unit per step
    for (genvar g = 0; g < NEWTON_STEPS; g++)
    begin : g_step
        fpr_newton u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (ch_valid[g]),
            .x_in      (ch_x[g]),
            .d_in      (ch_d[g]),
            .scale_in  (ch_scale[g]),
            .out_valid (ch_valid[g+1]),
            .x_out     (ch_x[g+1]),
            .d_out     (ch_d[g+1]),
            .scale_out (ch_scale[g+1])
        );
    end

    // rescale and restore sign; its last register is the output register
    fpr_denorm u_denorm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (ch_valid[NEWTON_STEPS]),
        .x_in      (ch_x[NEWTON_STEPS]),
        .scale_in  (ch_scale[NEWTON_STEPS]),
        .out_valid (m_tvalid),
        .result    (m_tdata)
    );

endmodule

@@ src/fpr_checker.sv @@
`timescale 1ns / 1ps

module fpr_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           s_tvalid,
    input logic           s_tready,
    input logic           m_tvalid,
    input logic           m_tready,
    input fpr_pkg::word_t m_tdata
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // the input side only backs off after an output stall
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready && s_tvalid))
        else $error("s_tready dropped without an output stall");

    // a parked input word means a result is waiting
    a_busy_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("skid full with no output word");

    // one output transfer frees the skid buffer
    a_ready_back: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready && m_tready |=> s_tready)
        else $error("s_tready did not recover after output drained");

endmodule

bind fixed_point_reciprocal_core fpr_checker u_fpr_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/sv/fixed_point_reciprocal_checker.sv @@
`timescale 1ns / 1ps

module fixed_point_reciprocal_checker #(
    parameter int NEWTON_STEPS = 4
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    input  logic           s_tready,
    input  fpr_pkg::word_t s_tdata,
    input  logic           m_tvalid,
    input  logic           m_tready,
    input  fpr_pkg::word_t m_tdata,
    output int unsigned    mismatches,
    output int unsigned    outstanding
);

    import fpr_pkg::*;

    localparam word_t UNITY      = word_t'(64'd1 << FRAC_BITS);
    localparam word_t ONE_HALF   = word_t'(64'd1 << (FRAC_BITS - 1));
    localparam word_t DOUBLE     = word_t'(64'd2 << FRAC_BITS);
    // seed line 48/17 - 32/17*d, coefficients floored
    localparam word_t SEED_BIAS  = word_t'((64'd48 << FRAC_BITS) / 64'd17);
    localparam word_t SEED_SLOPE = word_t'((64'd32 << FRAC_BITS) / 64'd17);

    typedef struct {
        word_t operand;
        word_t recip;
    } recip_pair_t;

    recip_pair_t recip_due[$];

    // full signed product, floored to the word's fraction bits, wrapped
    function automatic word_t frac_product(input word_t a, input word_t b);
        logic signed [2*WORD_BITS-1:0] wide_a;
        logic signed [2*WORD_BITS-1:0] wide_b;
        logic signed [2*WORD_BITS-1:0] full;
        wide_a = a;
        wide_b = b;
        full   = wide_a * wide_b;
        return full[FRAC_BITS +: WORD_BITS];
    endfunction

    function automatic word_t newton_reciprocal(input word_t value);
        logic  neg;
        word_t d;
        word_t x;
        word_t z;
        int    rs;
        int    ls;
        neg = value[WORD_BITS-1];
        d   = neg ? -value : value;
        rs  = 0;
        ls  = 0;
        // above one: bring the top bit down to the half position
        if (UNITY < d) begin
            for (int i = FRAC_BITS; i < WORD_BITS; i++)
                if (d[i])
                    rs = i - FRAC_BITS + 1;
            d = d >>> rs;
        end
        // below one half: bring the top fraction bit up; zero and the
        // wrapped most negative value find nothing
        if (d < ONE_HALF) begin
            for (int i = 0; i < FRAC_BITS - 1; i++)
                if (d[i])
                    ls = FRAC_BITS - 1 - i;
            d = d << ls;
        end
        x = SEED_BIAS - frac_product(SEED_SLOPE, d);
        for (int n = 0; n < NEWTON_STEPS; n++)
            x = frac_product(x, DOUBLE - frac_product(x, d));
        // same shift, same direction as the operand got
        if (rs > 0)
            z = x >>> rs;
        else if (ls > 0)
            z = x << ls;
        else
            z = x;
        return neg ? -z : z;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        recip_pair_t due;
        if (!rst_n) begin
            recip_due.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else begin
            if (s_tvalid && s_tready)
                recip_due.push_back('{s_tdata, newton_reciprocal(s_tdata)});
            if (m_tvalid && m_tready) begin
                if (recip_due.size() == 0) begin
                    $error("reciprocal: expected no word, got %h", m_tdata);
                    mismatches <= mismatches + 1;
                end
                else begin
                    due = recip_due.pop_front();
                    if (m_tdata !== due.recip) begin
                        $error("reciprocal: expected %h, got %h (value %h)",
                               due.recip, m_tdata, due.operand);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            outstanding <= recip_due.size();
        end
    end

endmodule

@@ tb/sv/fixed_point_reciprocal_core_test.sv @@
`timescale 1ns / 1ps

module fixed_point_reciprocal_core_test;

    import fpr_pkg::*;

    localparam int NEWTON_STEPS   = 4;
    // pipe depth, the sum of the stages listed at the head of the core
    localparam int PIPE_DEPTH     = 6 + 2 * NEWTON_STEPS;
    // cycles without any accepted word before the run is declared hung
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_WORDS    = 380;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    word_t       s_tdata  = '0;       // [31:0] value
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    word_t       m_tdata;             // [31:0] reciprocal

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned send_idle_pct = 0;   // chance the source idles a cycle
    int unsigned stall_pct     = 0;   // chance the sink holds off a cycle
    int unsigned quiet_cycles  = 0;

    fixed_point_reciprocal_core #(
        .NEWTON_STEPS (NEWTON_STEPS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // watches both channels, predicts every reciprocal and compares
    fixed_point_reciprocal_checker #(
        .NEWTON_STEPS (NEWTON_STEPS)
    ) u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sink side back-pressure, redrawn every cycle
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // hang detector: any accepted word on either side restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** fixed_point_reciprocal_core: FAILED **");
            $finish;
        end
    end

    // offers one word, holds it until taken, then idles cycle by cycle
    task automatic send_word(input word_t value);
        s_tdata  <= value;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // stop sending until the pipe has handed back every reciprocal
    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // operands spread over every magnitude, both signs and the corner values
    function automatic word_t random_operand();
        word_t       w;
        int unsigned pick;
        pick = $urandom_range(9);
        w    = $urandom;
        if (pick >= 4 && pick <= 7)
        begin
            // random magnitude: exercises every normalize shift
            w = w >> $urandom_range(WORD_BITS - 1);
            if ($urandom_range(1))
                w = -w;
        end
        else if (pick == 8)
        begin
            // powers of two and their neighbors
            w = word_t'(64'd1 << $urandom_range(WORD_BITS - 1));
            w = w + word_t'($urandom_range(2)) - word_t'(1);
            if ($urandom_range(1))
                w = -w;
        end
        else if (pick == 9)
        begin
            case ($urandom_range(6))
                0:       w = '0;
                1:       w = word_t'(1);
                2:       w = word_t'(-1);
                3:       w = {1'b1, {(WORD_BITS-1){1'b0}}};
                4:       w = {1'b0, {(WORD_BITS-1){1'b1}}};
                5:       w = word_t'(64'd1 << FRAC_BITS);
                default: w = word_t'(64'd1 << (FRAC_BITS - 1));
            endcase
        end
        return w;
    endfunction

    initial
    begin
        word_t       corner_words[$];
        int unsigned idle_choice[3];
        corner_words = '{
            32'h0000_0000,    // zero: plain iteration from the seed
            32'h0000_0001,    // smallest positive
            32'hffff_ffff,    // smallest negative
            32'h7fff_ffff,    // largest positive, widest right shift
            32'h8000_0000,    // most negative, negation wraps
            32'h8000_0001,
            32'h0001_0000,    // exactly one, no shift
            32'hffff_0000,    // minus one
            32'h0000_8000,    // exactly one half, no shift
            32'h0000_7fff,    // just below one half
            32'h0001_0001,    // just above one
            32'h0000_ffff,    // just below one
            32'h0002_0000,
            32'h0000_4000,
            32'h0003_0000,
            32'h0001_8000,
            32'h4000_0000,
            32'hc000_0000,
            32'h0000_0100,
            32'hffff_fff0,
            32'h5555_5555,
            32'haaaa_aaaa,
            32'h0000_0002
        };
        idle_choice = '{0, 31, 69};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners, back to back
        foreach (corner_words[i])
            send_word(corner_words[i]);
        drain_pipe();

        // phase 0: full rate both sides
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (PHASE_WORDS) send_word(random_operand());

        // phase 1: sender mostly idle
        send_idle_pct = 69;
        stall_pct     = 0;
        repeat (PHASE_WORDS) send_word(random_operand());

        // phase 2: sink mostly stalled, then let everything drain
        send_idle_pct = 0;
        stall_pct     = 69;
        repeat (PHASE_WORDS) send_word(random_operand());
        drain_pipe();

        // phase 3: both sides idle now and then
        send_idle_pct = 31;
        stall_pct     = 31;
        repeat (PHASE_WORDS) send_word(random_operand());

        // phase 4: idling settings reshuffled every few dozen words
        repeat (PHASE_WORDS / 38)
        begin
            send_idle_pct = idle_choice[$urandom_range(2)];
            stall_pct     = idle_choice[$urandom_range(2)];
            repeat (38) send_word(random_operand());
        end

        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (2 * PIPE_DEPTH) @(posedge clk);

        if (mismatches == 0)
            $display("** fixed_point_reciprocal_core: PASSED **");
        else
            $display("** fixed_point_reciprocal_core: FAILED **");
        $finish;
    end

endmodule
